// ----- design/lfia_pkg.sv -----
// Shared constants, codes and types for the lowest free ID allocator.
`default_nettype none

package lfia_pkg;

    localparam int ID_W      = 8;
    localparam int ID_COUNT  = 2 ** ID_W;
    localparam int GRP_W     = 16;
    localparam int GRP_N     = ID_COUNT / GRP_W;
    localparam int GRP_IDX_W = $clog2(GRP_W);
    localparam int GRP_SEL_W = $clog2(GRP_N);

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_USED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CFG   = 3'd4;

    localparam logic REG_LOW_ID  = 1'b0;
    localparam logic REG_HIGH_ID = 1'b1;

    typedef logic [ID_W-1:0] id_t;

    typedef struct packed {
        id_t low_id;
        id_t high_id;
    } cfg_t;

    typedef struct packed {
        logic found;
        id_t  id;
    } find_t;

    typedef struct packed {
        logic en;
        id_t  id;
        logic val;
    } upd_t;

endpackage

`default_nettype wire

// ----- design/lfia_req_if.sv -----
// Request channel interface: operation and ID.
`default_nettype none

interface lfia_req_if
    import lfia_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    id_t               req_id;

    modport source (output valid, output func, output req_id, input ready);
    modport sink   (input valid, input func, input req_id, output ready);
endinterface

`default_nettype wire

// ----- design/lfia_rsp_if.sv -----
// Response channel interface: granted ID, status and query answer.
`default_nettype none

interface lfia_rsp_if
    import lfia_pkg::*;
();
    logic                valid;
    logic                ready;
    id_t                 granted_id;
    logic [STATUS_W-1:0] status;
    logic                in_use;

    modport source (output valid, output granted_id, output status, output in_use,
                    input ready);
    modport sink   (input valid, input granted_id, input status, input in_use,
                    output ready);
endinterface

`default_nettype wire

// ----- design/lfia_cfg_regs.sv -----
// APB configuration registers holding the low and high ID bounds.
`default_nettype none

module lfia_cfg_regs
    import lfia_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);
    cfg_t cfg_reg;
    logic reg_sel;
    logic wr_en;

    assign reg_sel = paddr[APB_AW-1];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_id  <= ID_W'(1);
            cfg_reg.high_id <= ID_W'(ID_COUNT - 1);
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_LOW_ID:  cfg_reg.low_id  <= pwdata[ID_W-1:0];
                REG_HIGH_ID: cfg_reg.high_id <= pwdata[ID_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LOW_ID:  prdata = APB_DW'(cfg_reg.low_id);
            REG_HIGH_ID: prdata = APB_DW'(cfg_reg.high_id);
        endcase
    end
endmodule

`default_nettype wire

// ----- design/lfia_used_map.sv -----
// Used bitmap, one flip-flop per ID, cleared at reset.
`default_nettype none

module lfia_used_map
    import lfia_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire upd_t                upd,
    output logic      [ID_COUNT-1:0] used_map
);
    logic [ID_COUNT-1:0] map_reg;

    assign used_map = map_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else if (upd.en)
        begin
            map_reg[upd.id] <= upd.val;
        end
    end
endmodule

`default_nettype wire

// ----- design/lfia_find_free.sv -----
// Two-level priority encoder for the lowest free ID inside the bounds.
`default_nettype none

module lfia_find_free
    import lfia_pkg::*;
(
    input  wire logic [ID_COUNT-1:0] used_map,
    input  wire id_t                 lo,
    input  wire id_t                 hi,
    output find_t                    res
);
    logic [ID_COUNT-1:0]  cand;
    logic [GRP_N-1:0]     grp_any;
    logic [GRP_IDX_W-1:0] grp_pos [GRP_N];
    logic [GRP_SEL_W-1:0] sel;

    always_comb
    begin
        for (int k = 0; k < ID_COUNT; k++)
        begin
            cand[k] = !used_map[k] && (ID_W'(k) >= lo) && (ID_W'(k) <= hi);
        end

        for (int g = 0; g < GRP_N; g++)
        begin
            grp_any[g] = |cand[g*GRP_W +: GRP_W];
            grp_pos[g] = '0;
            for (int b = GRP_W - 1; b >= 0; b--)
            begin
                if (cand[g*GRP_W + b])
                begin
                    grp_pos[g] = GRP_IDX_W'(b);
                end
            end
        end

        sel = '0;
        for (int g = GRP_N - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                sel = GRP_SEL_W'(g);
            end
        end

        res.found = |grp_any;
        res.id    = {sel, grp_pos[sel]};
    end
endmodule

`default_nettype wire

// ----- design/lowest_free_id_allocator.sv -----
// Top level of the lowest free ID allocator.
// Serves one allocate, free or query transaction per clock cycle while the response
// channel is not stalled: an accepted request is held in the request register, then the
// decode, the lowest-free search over the used bitmap and the bitmap update complete in a
// single pass into the response register. The bitmap update loop (two-level priority
// encoder feeding the bitmap flip-flops) sets this rate. The bitmap is cleared at reset
// with no sweep; write low_id and high_id over APB only while no transaction is in
// flight.
`default_nettype none

module lowest_free_id_allocator
    import lfia_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    lfia_req_if.sink               req,
    lfia_rsp_if.source             rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);
    cfg_t                cfg;
    find_t               find;
    upd_t                upd;
    logic [ID_COUNT-1:0] used_map;
    id_t                 eff_low;
    logic                bad_cfg;

    logic                req_valid_reg;
    logic [FUNC_W-1:0]   func_reg;
    id_t                 req_id_reg;

    logic                rsp_valid_reg;
    id_t                 granted_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                in_use_reg;

    id_t                 granted_next;
    logic [STATUS_W-1:0] status_next;
    logic                in_use_next;

    logic                advance;
    logic                take;

    lfia_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfia_used_map u_used_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (upd),
        .used_map (used_map)
    );

    lfia_find_free u_find_free (
        .used_map (used_map),
        .lo       (eff_low),
        .hi       (cfg.high_id),
        .res      (find)
    );

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign take      = req_valid_reg && advance;
    assign req.ready = !req_valid_reg || advance;

    assign eff_low = (cfg.low_id == '0) ? ID_W'(1) : cfg.low_id;
    assign bad_cfg = eff_low >= cfg.high_id;

    always_comb
    begin
        granted_next = '0;
        status_next  = ST_OK;
        in_use_next  = 1'b0;
        upd          = '0;
        unique case (func_reg)
            FUNC_ALLOC:
            begin
                if (bad_cfg)
                begin
                    status_next = ST_BAD_CFG;
                end
                else if (find.found)
                begin
                    granted_next = find.id;
                    upd.en       = take;
                    upd.id       = find.id;
                    upd.val      = 1'b1;
                end
                else
                begin
                    status_next = ST_EXHAUSTED;
                end
            end
            FUNC_FREE:
            begin
                if (bad_cfg)
                begin
                    status_next = ST_BAD_CFG;
                end
                else if (req_id_reg == '0 || req_id_reg > cfg.high_id)
                begin
                    status_next = ST_RANGE;
                end
                else if (!used_map[req_id_reg])
                begin
                    status_next = ST_NOT_USED;
                end
                else
                begin
                    upd.en  = take;
                    upd.id  = req_id_reg;
                    upd.val = 1'b0;
                end
            end
            FUNC_QUERY:
            begin
                if (bad_cfg)
                begin
                    status_next = ST_BAD_CFG;
                end
                else
                begin
                    in_use_next = used_map[req_id_reg];
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg   <= req.func;
            req_id_reg <= req.req_id;
        end
        if (take)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
            in_use_reg  <= in_use_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.granted_id = granted_reg;
    assign rsp.status     = status_reg;
    assign rsp.in_use     = in_use_reg;
endmodule

`default_nettype wire

// ----- design/lfia_checker.sv -----
// Port-level checker for the allocator response channel, bound to the top level.
`default_nettype none

module lfia_checker
    import lfia_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                valid,
    input wire logic                ready,
    input wire id_t                 granted_id,
    input wire logic [STATUS_W-1:0] status,
    input wire logic                in_use
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(granted_id) && $stable(status)
                            && $stable(in_use))
        else $error("response changed while stalled");

    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != ST_OK |-> granted_id == '0 && !in_use)
        else $error("failed transaction carries a grant or query answer");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid && granted_id != '0 |-> status == ST_OK && !in_use)
        else $error("grant with bad status or query answer");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> status <= ST_BAD_CFG)
        else $error("undefined status code");
endmodule

bind lowest_free_id_allocator lfia_checker u_lfia_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (rsp.valid),
    .ready      (rsp.ready),
    .granted_id (rsp.granted_id),
    .status     (rsp.status),
    .in_use     (rsp.in_use)
);

`default_nettype wire

// ----- sim/lfia_grant_checker.sv -----
// Watches the allocator channels and APB port, predicts each response and compares it.
`timescale 1ns / 100ps

module lfia_grant_checker
    import lfia_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    lfia_req_if                    req,
    lfia_rsp_if                    rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    input  wire logic [APB_DW-1:0] prdata,
    input  wire logic              pready,
    output int                     errors,
    output int                     pending
);

    localparam logic [APB_AW-1:0] ADDR_LOW_ID  = {REG_LOW_ID, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_HIGH_ID = {REG_HIGH_ID, 2'b00};

    typedef struct packed {
        id_t                 granted_id;
        logic [STATUS_W-1:0] status;
        logic                in_use;
    } outcome_t;

    id_t      cfg_low;
    id_t      cfg_high;
    logic     used_map [ID_COUNT];
    outcome_t awaited_outcomes [$];

    task automatic note_mismatch(input string what, input int exp_val, input int act_val);
        errors = errors + 1;
        if (errors <= 10)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, what,
                     exp_val, act_val);
    endtask

    function automatic outcome_t serve_request(input logic [FUNC_W-1:0] f, input id_t id);
        outcome_t o;
        int       lo;
        o  = '0;
        lo = (cfg_low == '0) ? 1 : int'(cfg_low);
        if (f == FUNC_ALLOC || f == FUNC_FREE || f == FUNC_QUERY)
        begin
            if (lo >= int'(cfg_high))
                o.status = ST_BAD_CFG;
            else if (f == FUNC_ALLOC)
            begin
                o.status = ST_EXHAUSTED;
                for (int k = lo; k <= int'(cfg_high); k++)
                begin
                    if (!used_map[k])
                    begin
                        used_map[k]  = 1'b1;
                        o.granted_id = id_t'(k);
                        o.status     = ST_OK;
                        break;
                    end
                end
            end
            else if (f == FUNC_FREE)
            begin
                if (id == '0 || id > cfg_high)
                    o.status = ST_RANGE;
                else if (!used_map[id])
                    o.status = ST_NOT_USED;
                else
                    used_map[id] = 1'b0;
            end
            else
                o.in_use = used_map[id];
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t exp_o;
        if (!rst_n)
        begin
            cfg_low  = id_t'(1);
            cfg_high = id_t'(255);
            for (int k = 0; k < ID_COUNT; k++)
                used_map[k] = 1'b0;
            awaited_outcomes.delete();
            errors  = 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == ADDR_LOW_ID)
                        cfg_low = pwdata[ID_W-1:0];
                    else if (paddr == ADDR_HIGH_ID)
                        cfg_high = pwdata[ID_W-1:0];
                end
                else if (paddr == ADDR_LOW_ID && prdata[ID_W-1:0] !== cfg_low)
                    note_mismatch("low_id readback", cfg_low, prdata[ID_W-1:0]);
                else if (paddr == ADDR_HIGH_ID && prdata[ID_W-1:0] !== cfg_high)
                    note_mismatch("high_id readback", cfg_high, prdata[ID_W-1:0]);
            end

            if (req.valid && req.ready)
                awaited_outcomes.push_back(serve_request(req.func, req.req_id));

            if (rsp.valid && rsp.ready)
            begin
                if (awaited_outcomes.size() == 0)
                    note_mismatch("unexpected transaction, granted_id", -1, rsp.granted_id);
                else
                begin
                    exp_o = awaited_outcomes.pop_front();
                    if (rsp.granted_id !== exp_o.granted_id)
                        note_mismatch("granted_id", exp_o.granted_id, rsp.granted_id);
                    if (rsp.status !== exp_o.status)
                        note_mismatch("status", exp_o.status, rsp.status);
                    if (rsp.in_use !== exp_o.in_use)
                        note_mismatch("in_use", exp_o.in_use, rsp.in_use);
                end
            end

            pending <= awaited_outcomes.size();
        end
    end

endmodule

// ----- sim/tb_lowest_free_id_allocator.sv -----
// Stimulus and verdict for the lowest free ID allocator.
`timescale 1ns / 100ps

module tb_lowest_free_id_allocator
    import lfia_pkg::*;
();

    localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [APB_AW-1:0] ADDR_LOW_ID  = {REG_LOW_ID, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_HIGH_ID = {REG_HIGH_ID, 2'b00};
    localparam int PHASES           = 15;
    localparam int PHASE_ITEMS      = 105;
    localparam int LONG_HOLD_CYCLES = 64;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                errors;
    int                pending;
    bit                quiet;
    bit                hold_rsp;

    lfia_req_if req_ch ();
    lfia_rsp_if rsp_ch ();

    lowest_free_id_allocator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lfia_grant_checker grant_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input id_t id);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid  <= 1'b0;
            req_ch.func   <= FUNC_W'($urandom);
            req_ch.req_id <= ID_W'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.func   <= f;
        req_ch.req_id <= id;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic drain;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [APB_AW-1:0] a,
                                input logic [APB_DW-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_range(input int lo, input int hi);
        apb_transfer(1'b1, ADDR_LOW_ID, APB_DW'(lo));
        apb_transfer(1'b1, ADDR_HIGH_ID, APB_DW'(hi));
        apb_transfer(1'b0, ADDR_LOW_ID, '0);
        apb_transfer(1'b0, ADDR_HIGH_ID, '0);
    endtask

    task automatic random_item(input int lo, input int hi);
        int   r;
        int   a;
        int   b;
        id_t  id;
        r = $urandom_range(0, 99);
        a = (lo < 2) ? 0 : lo - 2;
        b = (hi > 253) ? 255 : hi + 2;
        if ($urandom_range(0, 9) == 0)
            id = ID_W'($urandom);
        else
            id = ID_W'($urandom_range(a, b));
        if (r < 45)
            send_item(FUNC_ALLOC, ID_W'($urandom));
        else if (r < 80)
            send_item(FUNC_FREE, id);
        else if (r < 95)
            send_item(FUNC_QUERY, id);
        else
            send_item(FUNC_UNUSED, ID_W'($urandom));
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int lo;
        int hi;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_ch.valid  = 1'b0;
        req_ch.func   = FUNC_ALLOC;
        req_ch.req_id = '0;
        quiet         = 1'b0;
        hold_rsp      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FUNC_QUERY, id_t'(0));
        send_item(FUNC_QUERY, id_t'(255));
        send_item(FUNC_FREE, id_t'(0));
        send_item(FUNC_FREE, id_t'(255));
        repeat (3) send_item(FUNC_ALLOC, id_t'(0));
        send_item(FUNC_QUERY, id_t'(2));
        send_item(FUNC_FREE, id_t'(2));
        send_item(FUNC_ALLOC, id_t'(255));
        send_item(FUNC_UNUSED, id_t'(255));
        send_item(FUNC_FREE, id_t'(1));
        drain();

        set_range(250, 255);
        repeat (7) send_item(FUNC_ALLOC, id_t'(0));
        send_item(FUNC_FREE, id_t'(3));
        send_item(FUNC_FREE, id_t'(0));
        drain();

        set_range(0, 3);
        repeat (3) send_item(FUNC_ALLOC, id_t'(0));
        send_item(FUNC_FREE, id_t'(200));
        send_item(FUNC_QUERY, id_t'(250));
        drain();

        set_range(5, 5);
        send_item(FUNC_ALLOC, id_t'(0));
        send_item(FUNC_FREE, id_t'(2));
        send_item(FUNC_QUERY, id_t'(2));
        drain();

        set_range(255, 0);
        send_item(FUNC_ALLOC, id_t'(0));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                lo = 0;
                hi = 255;
            end
            else if (p == PHASES - 1)
            begin
                lo = 1;
                hi = 255;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                lo = $urandom_range(0, 255);
                hi = $urandom_range(0, lo);
            end
            else
            begin
                lo = $urandom_range(0, 250);
                hi = lo + $urandom_range(2, 30);
                if (hi > 255)
                    hi = 255;
            end
            quiet = (p >= PHASES - 2);
            set_range(lo, hi);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == 20)
                    hold_rsp = 1'b1;
                random_item(lo, hi);
            end
            drain();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/lfia_pkg.sv
design/lfia_req_if.sv
design/lfia_rsp_if.sv
design/lfia_cfg_regs.sv
design/lfia_used_map.sv
design/lfia_find_free.sv
design/lowest_free_id_allocator.sv
design/lfia_checker.sv
sim/lfia_grant_checker.sv
sim/tb_lowest_free_id_allocator.sv
